// File: src/mpcs_pkg.sv
// ----------------------------------------------------------------------------
// mpcs_pkg: shared types and constants for the multi-policy CPU scheduler
// Holds policy codes, register indexes and the controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none
package mpcs_pkg;
	localparam logic [1:0] POL_FCFS = 2'd0;
	localparam logic [1:0] POL_SJF  = 2'd1;
	localparam logic [1:0] POL_RR   = 2'd2;
	localparam logic [1:0] POL_SRTF = 2'd3;

	localparam logic REG_POLICY  = 1'b0;
	localparam logic REG_QUANTUM = 1'b1;

	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	// commands from controller to datapath
	typedef struct packed {
		logic scan_clr;   // reset the scan cursor and best candidate
		logic scan_step;  // examine one entry
		logic enq_pre;    // scan pushes arrivals at the current time
		logic enq_post;   // scan pushes arrivals at the next time
		logic pick;       // scan searches for the best eligible entry
		logic do_add;     // store the pending add
		logic sel_load;   // settle the served entry for this tick
		logic serve;      // serve one unit and emit the result, except under round robin
		logic requeue;    // push the preempted task after the slice ends; emit the round robin result
		logic emit_add;   // emit the add result
	} mpcs_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic scan_last;
	} mpcs_sts_t;
endpackage
`default_nettype wire

// File: src/multi_policy_cpu_scheduler.sv
// ----------------------------------------------------------------------------
// multi_policy_cpu_scheduler: tick-driven CPU scheduler
// FCFS, SJF, round robin and SRTF over a task table of MAX_TASKS entries.
// ----------------------------------------------------------------------------
// Usage
//   Raise start with action and the task fields while busy is low; the item
//   transfers at that edge and busy rises. Each item yields exactly one
//   result, shown for one cycle with result_valid high; the receiver cannot
//   stall it, so capture it on that cycle.
//   A tick under FCFS, SJF or SRTF scans the table one entry a cycle, then
//   serves. A round robin tick scans twice, for arrivals at the current
//   time and at the next, and serves between the two scans.
//   Write policy or quantum on the cfg port only while busy is low; a policy
//   write empties the ready FIFO and drops the current task.
//   Reset empties the table, zeroes time and selects FCFS with quantum one.
// ----------------------------------------------------------------------------
`default_nettype none
module multi_policy_cpu_scheduler
	import mpcs_pkg::*;
#(
	parameter int MAX_TASKS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [15:0] task_pid,
	input  wire logic [31:0] task_arrival,
	input  wire logic [15:0] task_burst,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [15:0] cfg_data,
	output logic             result_valid,
	output logic             add_refused,
	output logic             cpu_idle,
	output logic [15:0]      running_pid,
	output logic             task_done,
	output logic [15:0]      done_pid,
	output logic [31:0]      done_arrival,
	output logic [15:0]      done_burst,
	output logic [31:0]      done_start,
	output logic [31:0]      done_finish,
	output logic [31:0]      time_now
);
	mpcs_cmd_t  cmd;
	mpcs_sts_t  sts;
	logic [1:0] policy;
	logic [15:0] pid_q, bur_q;
	logic [31:0] arr_q;

	// hold the add fields for the cycle after the transfer
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pid_q <= task_pid;
			arr_q <= task_arrival; bur_q <= task_burst;
		end
	end

	mpcs_ctrl u_ctrl (
		.clk, .arst_n, .start(start && !busy), .action, .policy, .sts,
		.busy, .cmd
	);

	mpcs_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
		.clk, .arst_n, .cmd,
		.task_pid(pid_q), .task_arrival(arr_q), .task_burst(bur_q),
		.cfg_we, .cfg_idx, .cfg_data, .policy, .sts,
		.result_valid, .add_refused, .cpu_idle, .running_pid, .task_done,
		.done_pid, .done_arrival, .done_burst, .done_start, .done_finish,
		.time_now
	);
endmodule
`default_nettype wire

// File: src/mpcs_ctrl.sv
// ----------------------------------------------------------------------------
// mpcs_ctrl: scheduler sequencer
// Steps the datapath through an add, or through the scan passes of a tick.
// ----------------------------------------------------------------------------
`default_nettype none
module mpcs_ctrl
	import mpcs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       action,
	input  wire logic [1:0] policy,
	input  wire mpcs_sts_t  sts,
	output logic            busy,
	output mpcs_cmd_t       cmd
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_PRE, ST_PICK, ST_SEL, ST_POST, ST_FIN, ST_ADD
	} state_t;
	state_t state_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.scan_clr = start;
			ST_PRE:  begin cmd.scan_step = 1'b1; cmd.enq_pre = 1'b1; end
			ST_PICK: begin cmd.scan_step = 1'b1; cmd.pick = 1'b1; end
			ST_SEL:  begin cmd.sel_load = 1'b1; end
			ST_POST: begin cmd.scan_step = 1'b1; cmd.enq_post = 1'b1;
				cmd.serve = 1'b0; end
			ST_FIN:  cmd.requeue = 1'b1;
			ST_ADD:  begin cmd.do_add = 1'b1; cmd.emit_add = 1'b1; end
			default: cmd = '0;
		endcase
		if (state_q == ST_SEL) cmd.serve = 1'b1;
		if (state_q == ST_SEL) cmd.scan_clr = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (start) begin
					busy <= 1'b1;
					if (action == ACT_ADD) state_q <= ST_ADD;
					else if (policy == POL_RR) state_q <= ST_PRE;
					else state_q <= ST_PICK;
				end
				ST_PRE:  if (sts.scan_last) state_q <= ST_SEL;
				ST_PICK: if (sts.scan_last) state_q <= ST_SEL;
				ST_SEL:  if (policy == POL_RR) state_q <= ST_POST;
					else begin state_q <= ST_IDLE; busy <= 1'b0; end
				ST_POST: if (sts.scan_last) state_q <= ST_FIN;
				ST_FIN:  begin state_q <= ST_IDLE; busy <= 1'b0; end
				ST_ADD:  begin state_q <= ST_IDLE; busy <= 1'b0; end
				default: begin state_q <= ST_IDLE; busy <= 1'b0; end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: src/mpcs_dp.sv
// ----------------------------------------------------------------------------
// mpcs_dp: scheduler datapath
// Task table, ready FIFO, time counter, scan cursor and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module mpcs_dp
	import mpcs_pkg::*;
#(
	parameter int MAX_TASKS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mpcs_cmd_t   cmd,
	input  wire logic [15:0] task_pid,
	input  wire logic [31:0] task_arrival,
	input  wire logic [15:0] task_burst,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [15:0] cfg_data,
	output logic [1:0]       policy,
	output mpcs_sts_t        sts,
	output logic             result_valid,
	output logic             add_refused,
	output logic             cpu_idle,
	output logic [15:0]      running_pid,
	output logic             task_done,
	output logic [15:0]      done_pid,
	output logic [31:0]      done_arrival,
	output logic [15:0]      done_burst,
	output logic [31:0]      done_start,
	output logic [31:0]      done_finish,
	output logic [31:0]      time_now
);
	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);
	localparam logic [IW-1:0] LAST = IW'(MAX_TASKS - 1);

	logic [15:0] quantum_q;
	logic [MAX_TASKS-1:0] valid_q, started_q, queued_q;
	logic [15:0] pid_q [MAX_TASKS];
	logic [31:0] arr_q [MAX_TASKS];
	logic [15:0] bur_q [MAX_TASKS];
	logic [15:0] rem_q [MAX_TASKS];
	logic [31:0] st_q  [MAX_TASKS];
	logic [IW-1:0] fifo_q [MAX_TASKS];
	logic [IW-1:0] head_q;
	logic [CW-1:0] fcnt_q, ecnt_q;
	logic [IW-1:0] cur_q;
	logic cur_v_q;
	logic [15:0] slice_q;
	logic [31:0] time_q;
	logic [IW-1:0] scan_q, best_q;
	logic best_v_q;
	logic [IW-1:0] pend_q;   // entry preempted at slice end
	logic pend_v_q;
	logic served_q;          // a task was served in this tick

	logic [31:0] nt;
	assign nt = (time_q == TIME_MAX) ? time_q : time_q + 32'd1;
	assign sts.scan_last = (scan_q == LAST);

	// combinational lookup of the lowest free table entry
	logic [IW-1:0] free_idx;
	logic free_v;
	always_comb begin
		free_idx = '0;
		free_v = 1'b0;
		for (int i = MAX_TASKS - 1; i >= 0; i--)
			if (!valid_q[i]) begin free_idx = IW'(i); free_v = 1'b1; end
	end

	logic [15:0] ka, kb;
	logic better;
	always_comb begin
		ka = '0; kb = '0;
		if (policy == POL_SJF) begin ka = bur_q[scan_q]; kb = bur_q[best_q]; end
		else if (policy == POL_SRTF) begin ka = rem_q[scan_q]; kb = rem_q[best_q]; end
		if (ka != kb) better = ka < kb;
		else if (arr_q[scan_q] != arr_q[best_q]) better = arr_q[scan_q] < arr_q[best_q];
		else better = pid_q[scan_q] < pid_q[best_q];
	end

	// the post-tick scan runs after time has advanced, so time_q is the new time
	logic enq_t_ok, push_en;
	logic [IW:0] psum;
	logic [IW-1:0] push_pos;
	always_comb begin
		enq_t_ok = valid_q[scan_q] && !queued_q[scan_q] && !(cur_v_q && cur_q == scan_q)
			&& !(pend_v_q && pend_q == scan_q)
			&& arr_q[scan_q] <= time_q && fcnt_q < FULL;
		push_en = (cmd.enq_pre || (cmd.enq_post && served_q)) && enq_t_ok;
		psum = (IW+1)'(head_q) + (IW+1)'(fcnt_q);
		push_pos = (psum >= (IW+1)'(MAX_TASKS)) ? IW'(psum - (IW+1)'(MAX_TASKS))
			: IW'(psum);
	end

	logic [IW-1:0] pop_idx;
	assign pop_idx = fifo_q[head_q];

	// settle the served entry combinationally in the serve cycle
	logic sel_v;
	logic [IW-1:0] sel_i;
	always_comb begin
		sel_v = 1'b0; sel_i = best_q;
		if (policy == POL_RR) begin
			if (cur_v_q) begin sel_v = 1'b1; sel_i = cur_q; end
			else if (fcnt_q != '0 && valid_q[pop_idx]) begin sel_v = 1'b1; sel_i = pop_idx; end
		end else if (policy == POL_SRTF) begin
			sel_v = best_v_q; sel_i = best_q;
		end else if (cur_v_q && valid_q[cur_q]) begin
			sel_v = 1'b1; sel_i = cur_q;
		end else begin
			sel_v = best_v_q; sel_i = best_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_add && task_burst != 16'd0 && ecnt_q < FULL && free_v) begin
			pid_q[free_idx] <= task_pid;
			arr_q[free_idx] <= task_arrival;
			bur_q[free_idx] <= task_burst;
			rem_q[free_idx] <= task_burst;
		end
		if (push_en) fifo_q[push_pos] <= scan_q;
		if (cmd.requeue && pend_v_q && fcnt_q < FULL) fifo_q[push_pos] <= pend_q;
		if (cmd.serve && sel_v) begin
			if (!started_q[sel_i]) st_q[sel_i] <= time_q;
			if (rem_q[sel_i] != 16'd0) rem_q[sel_i] <= rem_q[sel_i] - 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy <= POL_FCFS; quantum_q <= 16'd1;
			valid_q <= '0; started_q <= '0; queued_q <= '0;
			head_q <= '0; fcnt_q <= '0; ecnt_q <= '0;
			cur_q <= '0; cur_v_q <= 1'b0; slice_q <= '0; time_q <= '0;
			scan_q <= '0; best_q <= '0; best_v_q <= 1'b0;
			pend_q <= '0; pend_v_q <= 1'b0; served_q <= 1'b0; result_valid <= 1'b0;
			add_refused <= 1'b0; cpu_idle <= 1'b0; running_pid <= '0;
			task_done <= 1'b0; done_pid <= '0; done_arrival <= '0;
			done_burst <= '0; done_start <= '0; done_finish <= '0; time_now <= '0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == REG_POLICY) begin
					policy <= cfg_data[1:0];
					queued_q <= '0; head_q <= '0; fcnt_q <= '0;
					cur_q <= '0; cur_v_q <= 1'b0; slice_q <= '0;
				end else quantum_q <= cfg_data;
			end
			if (cmd.scan_clr) begin
				scan_q <= '0; best_v_q <= 1'b0; pend_v_q <= 1'b0;
			end
			if (cmd.scan_step) scan_q <= scan_q + IW'(1);
			if (push_en) begin
				queued_q[scan_q] <= 1'b1;
				fcnt_q <= fcnt_q + CW'(1);
			end
			if (cmd.pick && valid_q[scan_q] && arr_q[scan_q] <= time_q
				&& (!best_v_q || better)) begin
				best_q <= scan_q; best_v_q <= 1'b1;
			end
			if (cmd.emit_add) begin
				result_valid <= 1'b1;
				cpu_idle <= 1'b0; running_pid <= '0; task_done <= 1'b0;
				done_pid <= '0; done_arrival <= '0; done_burst <= '0;
				done_start <= '0; done_finish <= '0; time_now <= time_q;
				if (task_burst != 16'd0 && ecnt_q < FULL && free_v) begin
					add_refused <= 1'b0;
					valid_q[free_idx] <= 1'b1; started_q[free_idx] <= 1'b0;
					queued_q[free_idx] <= 1'b0; ecnt_q <= ecnt_q + CW'(1);
				end else add_refused <= 1'b1;
			end
			if (cmd.serve) begin
				// best_q becomes the served entry for the scan that follows
				best_q <= sel_i; best_v_q <= sel_v;
				served_q <= sel_v;
				time_q <= nt;
				add_refused <= 1'b0;
				done_pid <= '0; done_arrival <= '0; done_burst <= '0;
				done_start <= '0; done_finish <= '0; task_done <= 1'b0;
				time_now <= nt;
				if (policy == POL_RR && !cur_v_q && fcnt_q != '0) begin
					head_q <= (head_q == LAST) ? '0 : head_q + IW'(1);
					fcnt_q <= fcnt_q - CW'(1);
					queued_q[pop_idx] <= 1'b0;
				end
				if (!sel_v) begin
					if (policy != POL_RR && policy != POL_SRTF) cur_v_q <= 1'b0;
					result_valid <= (policy != POL_RR);
					cpu_idle <= 1'b1; running_pid <= '0;
				end else begin
					cpu_idle <= 1'b0; running_pid <= pid_q[sel_i];
					started_q[sel_i] <= 1'b1;
					if (policy != POL_SRTF) begin cur_q <= sel_i; cur_v_q <= 1'b1; end
					if (policy == POL_RR && !cur_v_q)
						slice_q <= (quantum_q == 16'd0) ? 16'd0 : quantum_q - 16'd1;
					else if (policy == POL_RR && slice_q != 16'd0)
						slice_q <= slice_q - 16'd1;
					if (rem_q[sel_i] <= 16'd1) begin
						task_done <= 1'b1; done_pid <= pid_q[sel_i];
						done_arrival <= arr_q[sel_i]; done_burst <= bur_q[sel_i];
						done_start <= started_q[sel_i] ? st_q[sel_i] : time_q;
						done_finish <= nt;
						valid_q[sel_i] <= 1'b0; started_q[sel_i] <= 1'b0;
						if (ecnt_q != '0) ecnt_q <= ecnt_q - CW'(1);
						cur_v_q <= 1'b0;
					end else if (policy == POL_RR &&
						((!cur_v_q && quantum_q <= 16'd1) || (cur_v_q && slice_q <= 16'd1))) begin
						cur_v_q <= 1'b0; pend_q <= sel_i; pend_v_q <= 1'b1;
					end
					if (policy != POL_RR) result_valid <= 1'b1;
				end
			end
			if (cmd.requeue) begin
				result_valid <= 1'b1;
				if (pend_v_q && fcnt_q < FULL) begin
					queued_q[pend_q] <= 1'b1;
					fcnt_q <= fcnt_q + CW'(1);
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/tb_multi_policy_cpu_scheduler.sv
// ----------------------------------------------------------------------------
// tb_multi_policy_cpu_scheduler: self-checking bench for the CPU scheduler
// Drives add and tick transfers under each policy and quantum, predicts every
// result with an in-bench scheduler model and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_multi_policy_cpu_scheduler;
	import mpcs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NTASK = 16;

	// ------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        action = ACT_ADD;
	logic [15:0] task_pid = '0;
	logic [31:0] task_arrival = '0;
	logic [15:0] task_burst = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = REG_POLICY;
	logic [15:0] cfg_data = '0;
	logic        result_valid, add_refused, cpu_idle, task_done;
	logic [15:0] running_pid, done_pid, done_burst;
	logic [31:0] done_arrival, done_start, done_finish, time_now;

	multi_policy_cpu_scheduler #(.MAX_TASKS(NTASK)) dut (.*);

	initial forever #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Pending transfers: scheduler items, or register writes between them
	// ------------------------------------------------------------------
	typedef struct {
		bit          is_cfg;
		logic        act;
		logic [15:0] pid;
		logic [31:0] arr;
		logic [15:0] bur;
		logic        ridx;
		logic [15:0] rdata;
	} pending_t;

	typedef struct packed {
		logic        refused;
		logic        idle;
		logic [15:0] run_pid;
		logic        done;
		logic [15:0] d_pid;
		logic [31:0] d_arr;
		logic [15:0] d_bur;
		logic [31:0] d_start;
		logic [31:0] d_finish;
		logic [31:0] now;
	} sched_res_t;

	pending_t   pending_q[$];
	sched_res_t expected_q[$];
	int         n_fail = 0;
	int         n_xfer = 0;

	// ------------------------------------------------------------------
	// Scheduler model state
	// ------------------------------------------------------------------
	logic [1:0]  m_policy;
	logic [15:0] m_quantum;
	bit          t_valid[NTASK];
	logic [15:0] t_pid[NTASK];
	logic [31:0] t_arr[NTASK];
	logic [15:0] t_bur[NTASK];
	logic [15:0] t_rem[NTASK];
	bit          t_started[NTASK];
	logic [31:0] t_start[NTASK];
	bit          t_queued[NTASK];
	int          rr_fifo[NTASK];
	int          rr_head, rr_count;
	int          cur_idx;
	bit          cur_valid;
	logic [15:0] slice_left;
	logic [31:0] clock_now;
	int          n_entries;

	function automatic void drop_schedule();
		for (int i = 0; i < NTASK; i++) begin
			t_queued[i] = 0;
			rr_fifo[i] = 0;
		end
		rr_head = 0;
		rr_count = 0;
		cur_idx = 0;
		cur_valid = 0;
		slice_left = '0;
	endfunction

	function automatic void model_reset();
		m_policy = POL_FCFS;
		m_quantum = 16'd1;
		for (int i = 0; i < NTASK; i++) begin
			t_valid[i] = 0;
			t_started[i] = 0;
		end
		drop_schedule();
		clock_now = '0;
		n_entries = 0;
	endfunction

	function automatic void rr_push(int idx);
		if (rr_count >= NTASK) return;
		rr_fifo[(rr_head + rr_count) % NTASK] = idx;
		t_queued[idx] = 1;
		rr_count++;
	endfunction

	function automatic int rr_pop();
		int idx;
		if (rr_count == 0) return -1;
		idx = rr_fifo[rr_head];
		rr_head = (rr_head + 1) % NTASK;
		rr_count--;
		t_queued[idx] = 0;
		if (!t_valid[idx]) return -1;
		return idx;
	endfunction

	// queue every eligible, unqueued, non-running task in table order
	function automatic void queue_arrivals(logic [31:0] t);
		for (int i = 0; i < NTASK; i++)
			if (t_valid[i] && !t_queued[i] && !(cur_valid && cur_idx == i) && t_arr[i] <= t)
				rr_push(i);
	endfunction

	function automatic bit prefer(int a, int b, logic [1:0] pol);
		logic [15:0] ka, kb;
		ka = '0;
		kb = '0;
		if (pol == POL_SJF) begin
			ka = t_bur[a];
			kb = t_bur[b];
		end else if (pol == POL_SRTF) begin
			ka = t_rem[a];
			kb = t_rem[b];
		end
		if (ka != kb) return ka < kb;
		if (t_arr[a] != t_arr[b]) return t_arr[a] < t_arr[b];
		return t_pid[a] < t_pid[b];
	endfunction

	function automatic int best_eligible(logic [31:0] t, logic [1:0] pol);
		int best;
		best = -1;
		for (int i = 0; i < NTASK; i++)
			if (t_valid[i] && t_arr[i] <= t && (best < 0 || prefer(i, best, pol)))
				best = i;
		return best;
	endfunction

	function automatic void apply_register(logic ridx, logic [15:0] data);
		if (ridx == REG_POLICY) begin
			m_policy = data[1:0];
			drop_schedule();
		end else begin
			m_quantum = data;
		end
	endfunction

	function automatic sched_res_t schedule_step(logic act, logic [15:0] pid,
			logic [31:0] arr, logic [15:0] bur);
		sched_res_t r;
		logic [31:0] t, nt;
		int sel, slot, p;
		r = '0;
		t = clock_now;
		sel = -1;
		if (act == ACT_ADD) begin
			slot = -1;
			if (bur != 0 && n_entries < NTASK)
				for (int i = NTASK - 1; i >= 0; i--)
					if (!t_valid[i]) slot = i;
			if (slot < 0) begin
				r.refused = 1'b1;
			end else begin
				t_valid[slot] = 1;
				t_pid[slot] = pid;
				t_arr[slot] = arr;
				t_bur[slot] = bur;
				t_rem[slot] = bur;
				t_started[slot] = 0;
				t_start[slot] = '0;
				t_queued[slot] = 0;
				n_entries++;
			end
			r.now = clock_now;
			return r;
		end
		if (m_policy == POL_RR) begin
			queue_arrivals(t);
			if (!cur_valid) begin
				p = rr_pop();
				if (p >= 0) begin
					cur_idx = p;
					cur_valid = 1;
					slice_left = (m_quantum != 0) ? m_quantum : 16'd1;
				end
			end
			if (cur_valid) sel = cur_idx;
		end else if (m_policy == POL_SRTF) begin
			sel = best_eligible(t, POL_SRTF);
		end else if (cur_valid && t_valid[cur_idx]) begin
			sel = cur_idx;
		end else begin
			cur_valid = 0;
			sel = best_eligible(t, m_policy);
			if (sel >= 0) begin
				cur_idx = sel;
				cur_valid = 1;
			end
		end
		nt = (t == TIME_MAX) ? t : t + 32'd1;
		clock_now = nt;
		r.now = nt;
		if (sel < 0) begin
			r.idle = 1'b1;
			return r;
		end
		if (!t_started[sel]) begin
			t_started[sel] = 1;
			t_start[sel] = t;
		end
		if (t_rem[sel] != 0) t_rem[sel]--;
		r.run_pid = t_pid[sel];
		if (m_policy == POL_RR) begin
			if (slice_left != 0) slice_left--;
			queue_arrivals(nt);
		end
		if (t_rem[sel] == 0) begin
			r.done = 1'b1;
			r.d_pid = t_pid[sel];
			r.d_arr = t_arr[sel];
			r.d_bur = t_bur[sel];
			r.d_start = t_start[sel];
			r.d_finish = nt;
			t_valid[sel] = 0;
			t_started[sel] = 0;
			if (n_entries > 0) n_entries--;
			if (cur_valid && cur_idx == sel) cur_valid = 0;
		end else if (m_policy == POL_RR && slice_left == 0) begin
			// slice over: requeue behind the arrivals just queued
			cur_valid = 0;
			rr_push(sel);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: one assignment per signal per edge, via next-state locals
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		bit       taken, gap;
		logic     nxt_start, nxt_we;
		pending_t head;
		taken = start && !busy;
		nxt_start = start;
		nxt_we = 1'b0;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
		end else begin
			if (taken) begin
				expected_q.push_back(schedule_step(action, task_pid, task_arrival, task_burst));
				n_xfer++;
			end
			// hold while the block has not taken the item
			if (!(start && busy)) begin
				nxt_start = 1'b0;
				gap = ($urandom_range(0, 99) < 15) && !(n_xfer >= 700 && n_xfer < 1000);
				if (pending_q.size() != 0) begin
					head = pending_q[0];
					if (head.is_cfg) begin
						// write only once the block is idle and drained
						if (!taken && !busy && !cfg_we && expected_q.size() == 0) begin
							nxt_we = 1'b1;
							cfg_idx <= head.ridx;
							cfg_data <= head.rdata;
							apply_register(head.ridx, head.rdata);
							void'(pending_q.pop_front());
						end
					end else if (!gap) begin
						nxt_start = 1'b1;
						action <= head.act;
						task_pid <= head.pid;
						task_arrival <= head.arr;
						task_burst <= head.bur;
						void'(pending_q.pop_front());
					end
				end
			end
			start <= nxt_start;
			cfg_we <= nxt_we;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: each strobed result against the oldest expectation
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		n_fail++;
	endtask

	always @(posedge clk) begin
		sched_res_t e;
		if (arst_n && result_valid) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing outstanding", $realtime);
				n_fail++;
			end else begin
				e = expected_q.pop_front();
				if (add_refused !== e.refused)
					report_mismatch("add_refused", 32'(add_refused), 32'(e.refused));
				if (cpu_idle !== e.idle)
					report_mismatch("cpu_idle", 32'(cpu_idle), 32'(e.idle));
				if (running_pid !== e.run_pid)
					report_mismatch("running_pid", 32'(running_pid), 32'(e.run_pid));
				if (task_done !== e.done)
					report_mismatch("task_done", 32'(task_done), 32'(e.done));
				if (done_pid !== e.d_pid)
					report_mismatch("done_pid", 32'(done_pid), 32'(e.d_pid));
				if (done_arrival !== e.d_arr) report_mismatch("done_arrival", done_arrival, e.d_arr);
				if (done_burst !== e.d_bur)
					report_mismatch("done_burst", 32'(done_burst), 32'(e.d_bur));
				if (done_start !== e.d_start) report_mismatch("done_start", done_start, e.d_start);
				if (done_finish !== e.d_finish) report_mismatch("done_finish", done_finish, e.d_finish);
				if (time_now !== e.now) report_mismatch("time_now", time_now, e.now);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	logic [31:0] gen_time = '0;  // ticks generated so far: the time at each item

	task automatic add_item(logic [15:0] pid, logic [31:0] arr, logic [15:0] bur);
		pending_t p;
		p = '{default: '0};
		p.act = ACT_ADD;
		p.pid = pid;
		p.arr = arr;
		p.bur = bur;
		pending_q.push_back(p);
	endtask

	task automatic tick_item();
		pending_t p;
		p = '{default: '0};
		p.act = ACT_TICK;
		p.pid = 16'($urandom);
		p.arr = $urandom;
		p.bur = 16'($urandom);
		pending_q.push_back(p);
		gen_time++;
	endtask

	task automatic reg_write(logic ridx, logic [15:0] data);
		pending_t p;
		p = '{default: '0};
		p.is_cfg = 1'b1;
		p.ridx = ridx;
		p.rdata = data;
		pending_q.push_back(p);
	endtask

	task automatic random_item();
		logic [31:0] arr;
		logic [15:0] pid, bur;
		int r;
		if ($urandom_range(0, 99) < 68) begin
			tick_item();
		end else begin
			pid = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
			r = $urandom_range(0, 99);
			if (r < 8)
				arr = gen_time - ((gen_time < 40) ? gen_time : 32'($urandom_range(0, 40)));
			else
				arr = gen_time + $urandom_range(0, 20);
			r = $urandom_range(0, 99);
			if (r < 3) begin
				bur = '0;
				arr = $urandom;  // refused, so any arrival will do
			end else if (r < 10) begin
				bur = 16'($urandom_range(5, 30));
			end else begin
				bur = 16'($urandom_range(1, 4));
			end
			add_item(pid, arr, bur);
		end
	endtask

	initial begin
		logic [1:0]  phase_pol[9];
		logic [15:0] phase_q[9];
		model_reset();

		// directed: refusal on zero burst, parked task at the far extremes,
		// fill the table, refusal when full, then drain by ticks
		add_item(16'h0000, 32'h0, 16'h0);
		add_item(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		for (int i = 0; i < 14; i++) add_item(16'(i % 3), 32'(i % 2), 16'(1 + i % 2));
		add_item(16'h1234, 32'h0, 16'h1);     // last free slot
		add_item(16'h4321, 32'h0, 16'h1);     // table full
		for (int i = 0; i < 6; i++) tick_item();
		reg_write(REG_QUANTUM, 16'h0000);     // zero quantum acts as one
		reg_write(REG_POLICY, 16'(POL_RR));
		for (int i = 0; i < 3; i++) tick_item();

		phase_pol = '{POL_FCFS, POL_SJF, POL_RR, POL_SRTF, POL_RR, POL_SJF, POL_RR,
			POL_FCFS, POL_SRTF};
		phase_q = '{16'd1, 16'd5, 16'hFFFF, 16'd2, 16'd1, 16'hAAAA, 16'd3, 16'h5555,
			16'd4};
		for (int ph = 0; ph < 9; ph++) begin
			reg_write(REG_QUANTUM, phase_q[ph]);
			reg_write(REG_POLICY, {14'($urandom_range(0, 16383)), phase_pol[ph]});
			for (int i = 0; i < 197; i++) random_item();
		end
		// drain whatever is left
		for (int i = 0; i < 150; i++) tick_item();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || start || expected_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (n_fail == 0)
			$display("PASS multi_policy_cpu_scheduler");
		else
			$display("FAIL multi_policy_cpu_scheduler");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5ms;
		$display("FAIL multi_policy_cpu_scheduler");
		$finish;
	end
endmodule
`default_nettype wire
